FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STEP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int LOC_W      = 11;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK = 1'b1;

  // Control characters and printable range
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_PRINT,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CELL_W-1:0] glyph;  // attribute and character for a print
    logic [LOC_W-1:0]  index;  // cell index for a read
  } op_t;

endpackage

FILE: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_cmd_if / tcw_res_if
// Valid/ready channels for commands and results of the text console writer.
// ----------------------------------------------------------------------------
interface tcw_cmd_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [LOC_W-1:0]  cell_index;

  modport source (output valid, output cmd, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input cmd, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [LOC_W-1:0]  cursor_location;
  logic [CELL_W-1:0] read_cell;

  modport source (output valid, output cursor_col, output cursor_row,
                  output cursor_location, output read_cell, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input cursor_location, input read_cell, output ready);
endinterface

FILE: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts commands, holds the color registers and classifies each command.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tcw_cmd_if.sink               cmd_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  input  logic                  init_busy,
  output logic                  push,
  output op_t                   push_op
);

  logic [COLOR_W-1:0] fore_color;
  logic [COLOR_W-1:0] back_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      fore_color <= COLOR_W'(15);
      back_color <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORE: fore_color <= cfg_data[COLOR_W-1:0];
        CFG_BACK: back_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off while the queue is full or the power-up blanking runs
  assign cmd_ch.ready = !q_full && !init_busy;
  assign push         = cmd_ch.valid && cmd_ch.ready;

  always_comb begin
    push_op.kind  = OP_NOP;
    push_op.glyph = {back_color, fore_color, cmd_ch.char_code};
    push_op.index = cmd_ch.cell_index;
    case (cmd_ch.cmd)
      CMD_PUT: begin
        case (cmd_ch.char_code)
          CH_BS:   push_op.kind = OP_BS;
          CH_TAB:  push_op.kind = OP_TAB;
          CH_CR:   push_op.kind = OP_CR;
          CH_LF:   push_op.kind = OP_LF;
          default: begin
            if (cmd_ch.char_code inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
              push_op.kind = OP_PRINT;
            end
          end
        endcase
      end
      CMD_CLEAR: push_op.kind = OP_CLEAR;
      CMD_READ:  push_op.kind = OP_READ;
      default:   push_op.kind = OP_NOP;
    endcase
  end

endmodule

FILE: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic full,
  output logic empty
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes operations: cursor, cell store, scroll and fill sequencer, result.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  op_t      q_head,
  output logic     q_pop,
  output logic     init_busy,
  tcw_res_if.source res_ch
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_FILL   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [LOC_W-1:0]  fill_addr;
  logic              fill_reply;
  logic [LOC_W-1:0]  src;
  logic              cp_valid;
  logic [LOC_W-1:0]  cp_addr;
  logic              rd_hit;
  logic [CELL_W-1:0] cell_q;

  logic              res_valid;
  logic              res_load;
  logic [COL_W-1:0]  res_col;
  logic [ROW_W-1:0]  res_row;
  logic [LOC_W-1:0]  res_loc;
  logic [CELL_W-1:0] res_cell;

  // Cell store
  logic [CELL_W-1:0] mem [CELLS];
  logic              wr_en;
  logic [LOC_W-1:0]  wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [LOC_W-1:0]  rd_addr;
  logic [CELL_W-1:0] rd_data;

  // Cursor update for put operations
  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    col_put;
  logic              lf;
  logic              wrap;
  logic [COL_W-1:0]  col_fin;
  logic [ROW_W:0]    row_ext;
  logic              scroll;
  logic [ROW_W-1:0]  row_fin;
  logic [LOC_W-1:0]  loc_cur;
  logic              rd_ok;
  logic              src_more;

  function automatic logic [LOC_W-1:0] loc_of(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    return LOC_W'(r * COLUMNS) + LOC_W'(c);
  endfunction

  assign loc_cur   = loc_of(row, col);
  assign rd_ok     = (q_head.index < LOC_W'(CELLS));
  assign src_more  = (src < LOC_W'(CELLS));
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign init_busy = (state == S_FILL) && !fill_reply;
  assign res_load  = (state == S_DONE) && (!res_valid || res_ch.ready);

  always_comb begin
    col_ext = {1'b0, col};
    col_put = col_ext;
    lf      = 1'b0;
    case (q_head.kind)
      OP_BS: begin
        if (col != '0) begin
          col_put = col_ext - 1'b1;
        end
      end
      OP_TAB: col_put = col_ext + (COL_W+1)'(TAB_STEP)
                        - (col_ext % (COL_W+1)'(TAB_STEP));
      OP_CR:  col_put = '0;
      OP_LF: begin
        col_put = '0;
        lf      = 1'b1;
      end
      OP_PRINT: col_put = col_ext + 1'b1;
      default: ;
    endcase
    wrap    = (col_put >= (COL_W+1)'(COLUMNS));
    col_fin = wrap ? '0 : col_put[COL_W-1:0];
    row_ext = {1'b0, row} + (ROW_W+1)'(lf || wrap);
    scroll  = (row_ext >= (ROW_W+1)'(ROWS));
    row_fin = scroll ? ROW_W'(ROWS - 1) : row_ext[ROW_W-1:0];
  end

  // One write and one read port per cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_addr;
    wr_data = BLANK_CELL;
    rd_en   = 1'b0;
    rd_addr = src;
    case (state)
      S_IDLE: begin
        if (!q_empty && q_head.kind == OP_PRINT) begin
          wr_en   = 1'b1;
          wr_addr = loc_cur;
          wr_data = q_head.glyph;
        end
        if (!q_empty && q_head.kind == OP_READ && rd_ok) begin
          rd_en   = 1'b1;
          rd_addr = q_head.index;
        end
      end
      S_SCROLL: begin
        wr_en   = cp_valid;
        wr_addr = cp_addr;
        wr_data = rd_data;
        rd_en   = src_more;
      end
      S_FILL:  wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_addr  <= '0;
      fill_reply <= 1'b0;
      col        <= '0;
      row        <= '0;
      cp_valid   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res_ch.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cell_q <= '0;
            rd_hit <= rd_ok;
            case (q_head.kind)
              OP_CLEAR: begin
                col        <= '0;
                row        <= '0;
                fill_addr  <= '0;
                fill_reply <= 1'b1;
                state      <= S_FILL;
              end
              OP_READ: state <= S_READ;
              default: begin
                col <= col_fin;
                row <= row_fin;
                if (scroll) begin
                  src      <= LOC_W'(COLUMNS);
                  cp_valid <= 1'b0;
                  state    <= S_SCROLL;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_READ: begin
          if (rd_hit) begin
            cell_q <= rd_data;
          end
          state <= S_DONE;
        end
        S_SCROLL: begin
          // Read one row down, write back on the following cycle
          cp_valid <= src_more;
          cp_addr  <= src - LOC_W'(COLUMNS);
          if (src_more) begin
            src <= src + 1'b1;
          end else begin
            fill_addr  <= LOC_W'(CELLS - COLUMNS);
            fill_reply <= 1'b1;
            state      <= S_FILL;
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == LOC_W'(CELLS - 1)) begin
            state <= fill_reply ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            res_valid <= 1'b1;
            res_col   <= col;
            res_row   <= row;
            res_loc   <= loc_cur;
            res_cell  <= cell_q;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_ch.valid           = res_valid;
  assign res_ch.cursor_col      = res_col;
  assign res_ch.cursor_row      = res_row;
  assign res_ch.cursor_location = res_loc;
  assign res_ch.read_cell       = res_cell;

endmodule

FILE: rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: 80x25 cell store, cursor, put/clear/read commands.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-------------------------------------
//   cmd_ch   | in  | valid/ready         | cmd, char_code, cell_index
//   res_ch   | out | valid/ready         | cursor_col, cursor_row,
//            |     |                     | cursor_location, read_cell
//   cfg      | in  | cfg_we, no stall    | cfg_index, cfg_data
//
// A put that moves the cursor passes the idle and done states before its result;
// a read also passes the read state (one registered read of the cell store).
// A put that scrolls copies 1920 cells through the single read and write port,
// then blanks the bottom row. A clear blanks all 2000 cells.
// After reset the back end blanks all 2000 cells and holds cmd_ch ready low;
// configuration writes are taken throughout.
// The two-entry queue lets the front take a command while the back works and
// while a result waits on res_ch.
module text_console_writer_unit import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tcw_cmd_if.sink               cmd_ch,
  tcw_res_if.source             res_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic push;
  op_t  push_op;
  logic pop;
  op_t  head;
  logic q_full;
  logic q_empty;
  logic init_busy;

  // Accept and classify commands, hold the color registers
  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .push_op   (push_op)
  );

  // Decouple front and back
  tcw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Execute operations against the cursor and cell store
  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (pop),
    .init_busy (init_busy),
    .res_ch    (res_ch)
  );

endmodule
